@@ rtl/grc_pkg.sv @@
// Shared types, constants and trig table of the grid ray caster
package grc_pkg;

    localparam int FRAME_RAYS  = 60;
    localparam int MAX_STEPS   = 20;
    localparam int MAP_COLUMNS = 16;
    localparam int MAP_ROWS    = 9;
    localparam int FAN_HALF    = 32;

    localparam int RAY_W     = 6;
    localparam int DEPTH_W   = 20;
    localparam int MAP_W     = 48;
    localparam int MAG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int DIST_W    = $clog2(256 * (MAX_STEPS + 1) + 1);
    localparam int NUM_W     = DIST_W + 14;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    localparam logic [MAP_W-1:0] MAP_0_2_RESET = 48'd172045652590591;
    localparam logic [MAP_W-1:0] MAP_3_5_RESET = 48'd141259599614017;
    localparam logic [MAP_W-1:0] MAP_6_8_RESET = 48'd281472838238209;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_0_2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_3_5 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_6_8 = 2'd2;

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_FRAME      = 4'd1;
    localparam logic [3:0] OP_TRIG       = 4'd2;
    localparam logic [3:0] OP_SETUP      = 4'd3;
    localparam logic [3:0] OP_DIV_OFF    = 4'd4;
    localparam logic [3:0] OP_SAVE_OFF   = 4'd5;
    localparam logic [3:0] OP_SAVE_STEP  = 4'd6;
    localparam logic [3:0] OP_WALK       = 4'd7;
    localparam logic [3:0] OP_DIV_DEPTH  = 4'd8;
    localparam logic [3:0] OP_SAVE_DEPTH = 4'd9;
    localparam logic [3:0] OP_PICK       = 4'd10;
    localparam logic [3:0] OP_MUL        = 4'd11;
    localparam logic [3:0] OP_EMIT       = 4'd12;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  view_angle;
    } item_t;

    typedef struct packed {
        logic [RAY_W-1:0]   ray_index;
        logic [DEPTH_W-1:0] wall_distance;
        logic               hit_vertical;
        logic               last_ray;
    } result_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic walk_end;
        logic side;
        logic ray_last;
        logic out_free;
    } status_t;

    localparam logic [MAG_W-1:0] QUARTER_WAVE [65] = '{
        15'd164,   15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
        15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
        15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
        15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
        15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
        15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
        15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
        15'd16384
    };

    function automatic logic signed [15:0] trig_q14(input logic [7:0] idx);
        logic [7:0] mirror;
        logic [7:0] back;
        logic [7:0] low;
        mirror = 8'(8'd0 - idx);
        back   = 8'(8'd128 - idx);
        low    = 8'(idx - 8'd128);
        if (idx <= 8'd64)
            return signed'({1'b0, QUARTER_WAVE[idx[6:0]]});
        else if (idx < 8'd128)
            return signed'({1'b0, QUARTER_WAVE[back[6:0]]});
        else if (idx == 8'd128)
            return 16'sd164;
        else if (idx <= 8'd192)
            return -signed'({1'b0, QUARTER_WAVE[low[6:0]]});
        else
            return -signed'({1'b0, QUARTER_WAVE[mirror[6:0]]});
    endfunction

endpackage

@@ rtl/grid_ray_caster.sv @@
// Top level of the grid ray caster: controller, datapath and configuration port
//
//  channel | signals                              | transfer when
//  item    | item_valid, item_ready, item         | item_valid && item_ready
//  result  | result_valid, result_ready, result   | result_valid && result_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// One item yields FRAME_RAYS results. Each ray makes two grid walks, each running the
// shared divider three times plus one to twenty map steps. The next item is taken
// once the last result of a frame sits in the output register. Reset restores the
// wall map; a stalled result holds the ray sequencer.
module grid_ray_caster (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  grc_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output grc_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [grc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [grc_pkg::MAP_W-1:0]        cfg_data
);

    grc_pkg::cmd_t    cmd;
    grc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    grc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    grc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ rtl/grc_div.sv @@
// Restoring divider, one quotient bit per cycle
module grc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grc_pkg::NUM_W-1:0]   num,
    input  logic [grc_pkg::MAG_W-1:0]   den,
    output logic                        done,
    output logic [grc_pkg::NUM_W-1:0]   quot,
    output logic [grc_pkg::MAG_W-1:0]   rem
);

    localparam int NUM_W = grc_pkg::NUM_W;
    localparam int MAG_W = grc_pkg::MAG_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [MAG_W-1:0] acc_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [MAG_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             fits;

    assign trial = {acc_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = acc_reg;

endmodule

@@ rtl/grc_dp.sv @@
// Datapath: map registers, ray walk arithmetic, correction and result register
module grc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  grc_pkg::cmd_t                    cmd,
    output grc_pkg::status_t                 status,
    input  grc_pkg::item_t                   item,
    input  logic                             cfg_valid,
    input  logic [grc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [grc_pkg::MAP_W-1:0]        cfg_data,
    output grc_pkg::result_t                 result,
    output logic                             result_valid,
    input  logic                             result_ready
);

    localparam int NUM_W  = grc_pkg::NUM_W;
    localparam int MAG_W  = grc_pkg::MAG_W;
    localparam int STEP_W = grc_pkg::STEP_W;
    localparam int DIST_W = grc_pkg::DIST_W;
    localparam int RAY_W  = grc_pkg::RAY_W;
    localparam int ST_W   = STEP_W + 6;
    localparam int OT_W   = NUM_W - 7;
    localparam int CORR_W = NUM_W + 1;
    localparam int MUL_W  = NUM_W + MAG_W;

    logic [grc_pkg::MAP_W-1:0] map0_reg, map1_reg, map2_reg;
    logic [11:0]               px_reg, py_reg;
    logic [7:0]                view_reg, ang_reg;
    logic [RAY_W-1:0]          ray_reg;
    logic signed [15:0]        s_reg, c_reg, f_reg;
    logic                      side_reg;
    logic [8:0]                first_reg;
    logic signed [5:0]         ftile_reg;
    logic                      dir_pos_reg;
    logic [MAG_W-1:0]          amag_reg, cmag_reg, r_reg, rs_reg;
    logic [NUM_W-1:0]          prod_reg, q_reg, qs_reg, dh_reg, dv_reg, d_reg;
    logic [STEP_W-1:0]         k_reg;
    logic                      vert_reg;
    logic [MUL_W-1:0]          mul_reg;
    grc_pkg::result_t          result_reg;
    logic                      result_valid_reg;

    logic [11:0]        own, other;
    logic signed [15:0] along, across;
    logic               along_pos, across_pos;
    logic [MAG_W-1:0]   amag_c, cmag_c;
    logic [8:0]         first_c;
    logic [5:0]         cell6;
    logic [5:0]         ftile_c;
    logic [23:0]        prod_c;

    logic signed [ST_W-1:0]    stile, ftile_ext, k_ext;
    logic signed [NUM_W+1:0]   pos, other_ext, q_ext;
    logic [OT_W-1:0]           otile;
    logic                      o_ok_col, o_ok_row, s_ok_col, s_ok_row;
    logic                      in_map;
    logic [3:0]                col_idx, row_idx;
    logic [255:0]              map_all;
    logic                      blocked;
    logic [MAG_W:0]            r_sum;
    logic                      wrap;
    logic [DIST_W-1:0]         dist_c;

    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_num, div_quot;
    logic [MAG_W-1:0]          div_rem;

    logic                      vert_c;
    logic [7:0]                fidx;
    logic [MUL_W-1:0]          mul_c;
    logic [CORR_W-1:0]         corr_c;
    logic [grc_pkg::DEPTH_W-1:0] sat_c;
    logic                      out_free;

    assign own        = side_reg ? px_reg : py_reg;
    assign other      = side_reg ? py_reg : px_reg;
    assign along      = side_reg ? c_reg : s_reg;
    assign across     = side_reg ? s_reg : c_reg;
    assign along_pos  = !along[15];
    assign across_pos = !across[15];
    assign amag_c     = along[15] ? MAG_W'(-along) : MAG_W'(along);
    assign cmag_c     = across[15] ? MAG_W'(-across) : MAG_W'(across);
    assign first_c    = along_pos ? 9'(9'd256 - {1'b0, own[7:0]}) : {1'b0, own[7:0]};
    assign cell6      = {2'b00, own[11:8]};
    assign ftile_c    = along_pos ? 6'(cell6 + 6'd1) : 6'(cell6 - 6'd1);
    assign prod_c     = first_c * cmag_c;

    assign ftile_ext = ST_W'(ftile_reg);
    assign k_ext     = signed'(ST_W'(k_reg));
    assign stile     = dir_pos_reg ? ftile_ext + k_ext : ftile_ext - k_ext;
    assign other_ext = signed'((NUM_W + 2)'(other));
    assign q_ext     = signed'({2'b00, q_reg});
    assign pos       = across_pos ? other_ext + q_ext : other_ext - q_ext;
    assign otile     = pos[NUM_W:8];

    assign o_ok_col = !pos[NUM_W+1] && (otile < OT_W'(grc_pkg::MAP_COLUMNS));
    assign o_ok_row = !pos[NUM_W+1] && (otile < OT_W'(grc_pkg::MAP_ROWS));
    assign s_ok_col = !stile[ST_W-1] && (stile < ST_W'(grc_pkg::MAP_COLUMNS));
    assign s_ok_row = !stile[ST_W-1] && (stile < ST_W'(grc_pkg::MAP_ROWS));
    assign in_map   = side_reg ? (s_ok_col && o_ok_row) : (o_ok_col && s_ok_row);
    assign col_idx  = side_reg ? stile[3:0] : otile[3:0];
    assign row_idx  = side_reg ? otile[3:0] : stile[3:0];
    assign map_all  = {112'd0, map2_reg, map1_reg, map0_reg};
    assign blocked  = !in_map || map_all[{row_idx, col_idx}];

    assign r_sum  = {1'b0, r_reg} + {1'b0, rs_reg};
    assign wrap   = r_sum >= {1'b0, amag_reg};
    assign dist_c = DIST_W'(first_reg) + DIST_W'({k_reg, 8'b0});

    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_reg;
        unique case (cmd.op)
            grc_pkg::OP_DIV_OFF:
            begin
                div_start = 1'b1;
                div_num   = prod_reg;
            end
            grc_pkg::OP_SAVE_OFF:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({cmag_reg, 8'b0});
            end
            grc_pkg::OP_DIV_DEPTH:
            begin
                div_start = 1'b1;
                div_num   = {dist_c, 14'b0};
            end
            default:
            begin
                div_start = 1'b0;
                div_num   = prod_reg;
            end
        endcase
    end

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (amag_reg),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign vert_c = dv_reg < dh_reg;
    assign fidx   = 8'(view_reg - ang_reg + 8'd64);
    assign mul_c  = d_reg * f_reg[MAG_W-1:0];
    assign corr_c = mul_reg[MUL_W-1:14];
    assign sat_c  = (corr_c > CORR_W'(grc_pkg::DEPTH_MAX)) ? grc_pkg::DEPTH_MAX
                                                            : corr_c[grc_pkg::DEPTH_W-1:0];
    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map0_reg         <= grc_pkg::MAP_0_2_RESET;
            map1_reg         <= grc_pkg::MAP_3_5_RESET;
            map2_reg         <= grc_pkg::MAP_6_8_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                priority case (cfg_index)
                    grc_pkg::CFG_MAP_0_2: map0_reg <= cfg_data;
                    grc_pkg::CFG_MAP_3_5: map1_reg <= cfg_data;
                    grc_pkg::CFG_MAP_6_8: map2_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == grc_pkg::OP_EMIT)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            grc_pkg::OP_FRAME:
            begin
                px_reg   <= item.pos_x;
                py_reg   <= item.pos_y;
                view_reg <= item.view_angle;
                ang_reg  <= 8'(item.view_angle - 8'(grc_pkg::FAN_HALF));
                ray_reg  <= '0;
            end
            grc_pkg::OP_TRIG:
            begin
                s_reg    <= grc_pkg::trig_q14(ang_reg);
                c_reg    <= grc_pkg::trig_q14(8'(ang_reg + 8'd64));
                side_reg <= 1'b0;
            end
            grc_pkg::OP_SETUP:
            begin
                first_reg   <= first_c;
                ftile_reg   <= signed'(ftile_c);
                dir_pos_reg <= along_pos;
                amag_reg    <= amag_c;
                cmag_reg    <= cmag_c;
                prod_reg    <= NUM_W'(prod_c);
                k_reg       <= '0;
            end
            grc_pkg::OP_SAVE_OFF:
            begin
                q_reg <= div_quot;
                r_reg <= div_rem;
            end
            grc_pkg::OP_SAVE_STEP:
            begin
                qs_reg <= div_quot;
                rs_reg <= div_rem;
            end
            grc_pkg::OP_WALK:
            begin
                if (!blocked)
                begin
                    k_reg <= k_reg + 1'b1;
                    q_reg <= q_reg + qs_reg + NUM_W'(wrap);
                    r_reg <= wrap ? MAG_W'(r_sum - {1'b0, amag_reg}) : r_sum[MAG_W-1:0];
                end
            end
            grc_pkg::OP_SAVE_DEPTH:
            begin
                if (side_reg)
                    dv_reg <= div_quot;
                else
                    dh_reg <= div_quot;
                side_reg <= !side_reg;
            end
            grc_pkg::OP_PICK:
            begin
                vert_reg <= vert_c;
                d_reg    <= vert_c ? dv_reg : dh_reg;
                f_reg    <= grc_pkg::trig_q14(fidx);
            end
            grc_pkg::OP_MUL:
            begin
                mul_reg <= f_reg[15] ? '0 : mul_c;
            end
            grc_pkg::OP_EMIT:
            begin
                result_reg.ray_index     <= ray_reg;
                result_reg.wall_distance <= sat_c;
                result_reg.hit_vertical  <= vert_reg;
                result_reg.last_ray      <= (ray_reg == RAY_W'(grc_pkg::FRAME_RAYS - 1));
                ang_reg                  <= 8'(ang_reg + 8'd1);
                ray_reg                  <= ray_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign status.div_done = div_done;
    assign status.walk_end = blocked || (k_reg == STEP_W'(grc_pkg::MAX_STEPS - 1));
    assign status.side     = side_reg;
    assign status.ray_last = (ray_reg == RAY_W'(grc_pkg::FRAME_RAYS - 1));
    assign status.out_free = out_free;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ rtl/grc_ctrl.sv @@
// Controller state machine sequencing rays, walks and divisions
module grc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output grc_pkg::cmd_t    cmd,
    input  grc_pkg::status_t status
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_TRIG       = 4'd1;
    localparam logic [3:0] S_SETUP      = 4'd2;
    localparam logic [3:0] S_DIV_OFF    = 4'd3;
    localparam logic [3:0] S_WAIT_OFF   = 4'd4;
    localparam logic [3:0] S_WAIT_STEP  = 4'd5;
    localparam logic [3:0] S_WALK       = 4'd6;
    localparam logic [3:0] S_DEPTH      = 4'd7;
    localparam logic [3:0] S_WAIT_DEPTH = 4'd8;
    localparam logic [3:0] S_PICK       = 4'd9;
    localparam logic [3:0] S_MUL        = 4'd10;
    localparam logic [3:0] S_EMIT       = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = grc_pkg::OP_NONE;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.op     = grc_pkg::OP_FRAME;
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.op     = grc_pkg::OP_TRIG;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.op     = grc_pkg::OP_SETUP;
                state_next = S_DIV_OFF;
            end
            S_DIV_OFF:
            begin
                cmd.op     = grc_pkg::OP_DIV_OFF;
                state_next = S_WAIT_OFF;
            end
            S_WAIT_OFF:
            begin
                if (status.div_done)
                begin
                    cmd.op     = grc_pkg::OP_SAVE_OFF;
                    state_next = S_WAIT_STEP;
                end
            end
            S_WAIT_STEP:
            begin
                if (status.div_done)
                begin
                    cmd.op     = grc_pkg::OP_SAVE_STEP;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.op = grc_pkg::OP_WALK;
                if (status.walk_end)
                    state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                cmd.op     = grc_pkg::OP_DIV_DEPTH;
                state_next = S_WAIT_DEPTH;
            end
            S_WAIT_DEPTH:
            begin
                if (status.div_done)
                begin
                    cmd.op     = grc_pkg::OP_SAVE_DEPTH;
                    state_next = status.side ? S_PICK : S_SETUP;
                end
            end
            S_PICK:
            begin
                cmd.op     = grc_pkg::OP_PICK;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = grc_pkg::OP_MUL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = grc_pkg::OP_EMIT;
                    state_next = status.ray_last ? S_IDLE : S_TRIG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/grc_checker.sv @@
// Port-level checks for the grid ray caster and their bind
module grc_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  grc_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  grc_pkg::result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while a frame is running");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item withdrawn or changed while waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_ray |->
            result.ray_index == grc_pkg::RAY_W'(grc_pkg::FRAME_RAYS - 1))
        else $error("last ray flag on wrong ray");

endmodule

bind grid_ray_caster grc_checker u_grc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
